>>> rtl/core/qan_pkg.sv
package qan_pkg;

  localparam int PW        = 16;
  localparam int FRAC_BITS = 14;
  localparam int NPART     = 4;
  localparam int PRODW     = 2 * PW;
  localparam int VW        = PRODW + 2;
  localparam int MAGW      = VW - 1;
  localparam int MW        = 30;
  localparam int TOP       = MW - 1;
  localparam int SW        = 2 * MW + 2;
  localparam int SQ_STEPS  = SW / 2;
  localparam int DW        = MW + 1;
  localparam int NW        = MW + FRAC_BITS + 1;
  localparam int QW        = FRAC_BITS + 1;
  localparam int PSW       = $clog2(MAGW + 1);

  typedef logic signed [PW-1:0] part_t;

  typedef enum logic [1:0] {
    MODE_MUL  = 2'd0,
    MODE_ADD  = 2'd1,
    MODE_SUB  = 2'd2,
    MODE_CONJ = 2'd3
  } mode_t;

  typedef struct packed {
    logic [NPART-1:0][MW-1:0] m;
    logic [NPART-1:0]         neg;
    logic                     zero;
  } side_t;

endpackage

>>> rtl/core/quaternion_arith_normalize.sv
// Quaternion arithmetic with unit-length normalization, Q1.14 parts. A command is
// taken on every clock edge where start is high; busy never rises, so a new item can
// be issued every cycle. Each result appears on the out_ ports for one cycle with
// out_valid set, in command order; the receiver cannot stall. The pipeline is made up
// of the square root (31 stages, one result bit each) and the four parallel restoring
// dividers (15 stages, one quotient bit each), plus ten stages of products, sums,
// magnitude, leading-one search and squares and two for the divider setup and the
// output clamp and sign. A zero-length result gives zeros with out_zero_length set.
module quaternion_arith_normalize (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic [1:0]     in_mode,
  input  qan_pkg::part_t in_a_x,
  input  qan_pkg::part_t in_a_y,
  input  qan_pkg::part_t in_a_z,
  input  qan_pkg::part_t in_a_w,
  input  qan_pkg::part_t in_b_x,
  input  qan_pkg::part_t in_b_y,
  input  qan_pkg::part_t in_b_z,
  input  qan_pkg::part_t in_b_w,
  output qan_pkg::part_t out_r_x,
  output qan_pkg::part_t out_r_y,
  output qan_pkg::part_t out_r_z,
  output qan_pkg::part_t out_r_w,
  output logic           out_zero_length,
  output logic           out_valid
);
  import qan_pkg::*;

  localparam int LAT = 10 + SQ_STEPS + QW + 2;
  localparam logic [QW-1:0] ONE_Q = QW'(1) << FRAC_BITS;

  logic  acc;
  part_t a_in [NPART];
  part_t b_in [NPART];

  assign busy = 1'b0;
  assign acc  = start && !busy;
  assign a_in[0] = in_a_x;
  assign a_in[1] = in_a_y;
  assign a_in[2] = in_a_z;
  assign a_in[3] = in_a_w;
  assign b_in[0] = in_b_x;
  assign b_in[1] = in_b_y;
  assign b_in[2] = in_b_z;
  assign b_in[3] = in_b_w;

  logic [8:0] pre_v_r;

  // stage 1: products
  logic signed [PRODW-1:0] pr_r [NPART][NPART];
  part_t                   a1_r [NPART];
  part_t                   b1_r [NPART];
  mode_t                   mode1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPART; i++) begin
      for (int j = 0; j < NPART; j++) begin
        pr_r[i][j] <= a_in[i] * b_in[j];
      end
      a1_r[i] <= a_in[i];
      b1_r[i] <= b_in[i];
    end
    mode1_r <= mode_t'(in_mode);
  end

  // stage 2: raw quaternion
  logic signed [VW-1:0] e [NPART][NPART];
  logic signed [VW-1:0] v_nxt [NPART];
  logic signed [VW-1:0] v2_r [NPART];

  always_comb begin
    for (int i = 0; i < NPART; i++) begin
      for (int j = 0; j < NPART; j++) begin
        e[i][j] = VW'(pr_r[i][j]);
      end
    end
    for (int i = 0; i < NPART; i++) begin
      v_nxt[i] = '0;
    end
    unique case (mode1_r)
      MODE_MUL: begin
        v_nxt[0] = e[0][3] + e[3][0] + e[1][2] - e[2][1];
        v_nxt[1] = e[1][3] + e[3][1] + e[2][0] - e[0][2];
        v_nxt[2] = e[2][3] + e[3][2] + e[0][1] - e[1][0];
        v_nxt[3] = e[3][3] - e[0][0] - e[1][1] - e[2][2];
      end
      MODE_ADD: begin
        for (int i = 0; i < NPART; i++) begin
          v_nxt[i] = VW'(a1_r[i]) + VW'(b1_r[i]);
        end
      end
      MODE_SUB: begin
        for (int i = 0; i < NPART; i++) begin
          v_nxt[i] = VW'(a1_r[i]) - VW'(b1_r[i]);
        end
      end
      MODE_CONJ: begin
        for (int i = 0; i < NPART - 1; i++) begin
          v_nxt[i] = -VW'(a1_r[i]);
        end
        v_nxt[NPART-1] = VW'(a1_r[NPART-1]);
      end
      default: begin
        for (int i = 0; i < NPART; i++) begin
          v_nxt[i] = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPART; i++) begin
      v2_r[i] <= v_nxt[i];
    end
  end

  // stage 3: magnitudes
  logic signed [VW-1:0] abs_nxt [NPART];
  logic [MAGW-1:0]      mag3_r [NPART];
  logic [NPART-1:0]     neg3_r;

  always_comb begin
    for (int i = 0; i < NPART; i++) begin
      abs_nxt[i] = v2_r[i][VW-1] ? -v2_r[i] : v2_r[i];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPART; i++) begin
      mag3_r[i] <= abs_nxt[i][MAGW-1:0];
      neg3_r[i] <= v2_r[i][VW-1];
    end
  end

  // stages 4 and 5: largest magnitude
  logic [MAGW-1:0]  max01_r, max23_r, mx5_r;
  logic [MAGW-1:0]  mag4_r [NPART];
  logic [MAGW-1:0]  mag5_r [NPART];
  logic [NPART-1:0] neg4_r, neg5_r;

  always_ff @(posedge clk) begin
    max01_r <= (mag3_r[0] > mag3_r[1]) ? mag3_r[0] : mag3_r[1];
    max23_r <= (mag3_r[2] > mag3_r[3]) ? mag3_r[2] : mag3_r[3];
    mag4_r  <= mag3_r;
    neg4_r  <= neg3_r;
    mx5_r   <= (max01_r > max23_r) ? max01_r : max23_r;
    mag5_r  <= mag4_r;
    neg5_r  <= neg4_r;
  end

  // stage 6: leading one position
  logic [PSW-1:0]   pos_nxt;
  logic [PSW-1:0]   pos6_r;
  logic             zero6_r;
  logic [MAGW-1:0]  mag6_r [NPART];
  logic [NPART-1:0] neg6_r;

  always_comb begin
    pos_nxt = '0;
    for (int i = 0; i < MAGW; i++) begin
      if (mx5_r[i]) pos_nxt = PSW'(i);
    end
  end

  always_ff @(posedge clk) begin
    pos6_r  <= pos_nxt;
    zero6_r <= (mx5_r == '0);
    mag6_r  <= mag5_r;
    neg6_r  <= neg5_r;
  end

  // stage 7: common shift so the largest part lies in [2^29, 2^30)
  logic [MAGW+MW-1:0] wide_nxt [NPART];
  side_t              sd_nxt;
  side_t              sd7_r;

  always_comb begin
    for (int i = 0; i < NPART; i++) begin
      if (pos6_r >= PSW'(TOP)) begin
        wide_nxt[i] = (MAGW + MW)'(mag6_r[i]) >> (pos6_r - PSW'(TOP));
      end else begin
        wide_nxt[i] = (MAGW + MW)'(mag6_r[i]) << (PSW'(TOP) - pos6_r);
      end
      sd_nxt.m[i] = wide_nxt[i][MW-1:0];
    end
    sd_nxt.neg  = neg6_r;
    sd_nxt.zero = zero6_r;
  end

  always_ff @(posedge clk) begin
    sd7_r <= sd_nxt;
  end

  // stages 8 to 10: sum of squares
  logic [2*MW-1:0] sqr8_r [NPART];
  logic [SW-1:0]   ps9_r [2];
  side_t           sd8_r, sd9_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPART; i++) begin
      sqr8_r[i] <= sd7_r.m[i] * sd7_r.m[i];
    end
    sd8_r    <= sd7_r;
    ps9_r[0] <= SW'(sqr8_r[0]) + SW'(sqr8_r[1]);
    ps9_r[1] <= SW'(sqr8_r[2]) + SW'(sqr8_r[3]);
    sd9_r    <= sd8_r;
  end

  // square root, one result bit per stage
  logic [SW-1:0]     sq_s_r   [SQ_STEPS+1];
  logic [SW-1:0]     sq_res_r [SQ_STEPS+1];
  side_t             sq_sd_r  [SQ_STEPS+1];
  logic [SQ_STEPS:0] sq_v_r;
  logic [SW-1:0]     sq_bit   [SQ_STEPS];
  logic [SW-1:0]     sq_trial [SQ_STEPS];
  logic [SW-1:0]     sq_s_nxt [SQ_STEPS];
  logic [SW-1:0]     sq_res_nxt [SQ_STEPS];

  always_comb begin
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_bit[k]   = SW'(1) << (SW - 2 - 2 * k);
      sq_trial[k] = sq_res_r[k] + sq_bit[k];
      if (sq_s_r[k] >= sq_trial[k]) begin
        sq_s_nxt[k]   = sq_s_r[k] - sq_trial[k];
        sq_res_nxt[k] = (sq_res_r[k] >> 1) + sq_bit[k];
      end else begin
        sq_s_nxt[k]   = sq_s_r[k];
        sq_res_nxt[k] = sq_res_r[k] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    sq_s_r[0]   <= ps9_r[0] + ps9_r[1];
    sq_res_r[0] <= '0;
    sq_sd_r[0]  <= sd9_r;
    for (int k = 0; k < SQ_STEPS; k++) begin
      sq_s_r[k+1]   <= sq_s_nxt[k];
      sq_res_r[k+1] <= sq_res_nxt[k];
      sq_sd_r[k+1]  <= sq_sd_r[k];
    end
  end

  // restoring dividers, one quotient bit per stage
  logic [DW-1:0]    d_fin;
  logic [NW-1:0]    num_nxt [NPART];
  logic [DW-1:0]    dv_rem_r [QW+1][NPART];
  logic [QW-1:0]    dv_lo_r  [QW+1][NPART];
  logic [QW-1:0]    dv_q_r   [QW+1][NPART];
  logic [DW-1:0]    dv_d_r   [QW+1];
  logic [NPART-1:0] dv_neg_r [QW+1];
  logic             dv_zero_r [QW+1];
  logic [QW:0]      dv_v_r;
  logic [DW:0]      dv_rr    [QW][NPART];
  logic [DW-1:0]    dv_rem_nxt [QW][NPART];
  logic             dv_qb    [QW][NPART];

  assign d_fin = sq_res_r[SQ_STEPS][DW-1:0];

  always_comb begin
    for (int i = 0; i < NPART; i++) begin
      num_nxt[i] = (NW'(sq_sd_r[SQ_STEPS].m[i]) << FRAC_BITS) + NW'(d_fin >> 1);
    end
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < NPART; i++) begin
        dv_rr[j][i] = {dv_rem_r[j][i], dv_lo_r[j][i][QW-1]};
        dv_qb[j][i] = (dv_rr[j][i] >= {1'b0, dv_d_r[j]});
        if (dv_qb[j][i]) begin
          dv_rem_nxt[j][i] = DW'(dv_rr[j][i] - {1'b0, dv_d_r[j]});
        end else begin
          dv_rem_nxt[j][i] = dv_rr[j][i][DW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NPART; i++) begin
      dv_rem_r[0][i] <= DW'(num_nxt[i][NW-1:QW]);
      dv_lo_r[0][i]  <= num_nxt[i][QW-1:0];
      dv_q_r[0][i]   <= '0;
    end
    dv_d_r[0]    <= d_fin;
    dv_neg_r[0]  <= sq_sd_r[SQ_STEPS].neg;
    dv_zero_r[0] <= sq_sd_r[SQ_STEPS].zero;
    for (int j = 0; j < QW; j++) begin
      for (int i = 0; i < NPART; i++) begin
        dv_rem_r[j+1][i] <= dv_rem_nxt[j][i];
        dv_lo_r[j+1][i]  <= dv_lo_r[j][i] << 1;
        dv_q_r[j+1][i]   <= {dv_q_r[j][i][QW-2:0], dv_qb[j][i]};
      end
      dv_d_r[j+1]    <= dv_d_r[j];
      dv_neg_r[j+1]  <= dv_neg_r[j];
      dv_zero_r[j+1] <= dv_zero_r[j];
    end
  end

  // output stage: clamp, sign, mask
  logic [QW-1:0]    qc_nxt [NPART];
  logic [PW+QW-1:0] qe_nxt [NPART];
  logic [PW+QW-1:0] qs_nxt [NPART];
  part_t            r_nxt  [NPART];
  part_t            r_r    [NPART];
  logic             zl_r;
  logic             ov_r;

  always_comb begin
    for (int i = 0; i < NPART; i++) begin
      qc_nxt[i] = (dv_q_r[QW][i] > ONE_Q) ? ONE_Q : dv_q_r[QW][i];
      qe_nxt[i] = (PW + QW)'(qc_nxt[i]);
      qs_nxt[i] = dv_neg_r[QW][i] ? -qe_nxt[i] : qe_nxt[i];
      r_nxt[i]  = dv_zero_r[QW] ? '0 : part_t'(qs_nxt[i][PW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    r_r  <= r_nxt;
    zl_r <= dv_zero_r[QW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_v_r <= '0;
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      pre_v_r <= {pre_v_r[7:0], acc};
      sq_v_r  <= {sq_v_r[SQ_STEPS-1:0], pre_v_r[8]};
      dv_v_r  <= {dv_v_r[QW-1:0], sq_v_r[SQ_STEPS]};
      ov_r    <= dv_v_r[QW];
    end
  end

  assign out_r_x         = r_r[0];
  assign out_r_y         = r_r[1];
  assign out_r_z         = r_r[2];
  assign out_r_w         = r_r[3];
  assign out_zero_length = zl_r;
  assign out_valid       = ov_r;

  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_length |->
      out_r_x == '0 && out_r_y == '0 && out_r_z == '0 && out_r_w == '0)
    else $error("zero length result with nonzero parts");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> ##LAT out_valid)
    else $error("transfer did not produce a result on time");

  a_no_stray: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(acc, LAT))
    else $error("result without a matching transfer");

endmodule
